@@ hdl/fls_pkg.sv @@
// ============================================================================
// fls_pkg: shared types and constants of the field line tracer.
// Holds the word formats, the sequencer state type, the request and
// register codes, and the fixed-point constants.
// ============================================================================
package fls_pkg;

    // Fixed-point format of positions, intensities and step lengths.
    localparam int FRAC_BITS       = 16;
    // Default number of charge cells in the ring.
    localparam int MAX_CHARGES_DEF = 16;
    // Most vertices one line can emit.
    localparam int MAX_VERTICES    = 64;

    // Dividend width of the shared divider: it covers the charge term,
    // the unit vector term and the step move.
    localparam int DIV_W = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;
    // Divisor width of the shared divider.
    localparam int DIV_V = 32;
    // Radicand width of the shared square root unit.
    localparam int SQ_W  = 64;

    // Request codes of the input word.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TRACE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CHARGE_COUNT = 3'd0;
    localparam logic [2:0] CFG_STEP_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_RADIUS       = 3'd2;
    localparam logic [2:0] CFG_PIECES       = 3'd3;
    localparam logic [2:0] CFG_MAX_SEGMENTS = 3'd4;

    // Input word.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         charge_slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] charge_amount;
        logic [11:0]        line_id;
    } in_t;

    // Output word, one per vertex.
    typedef struct packed {
        logic [11:0]        out_line_id;
        logic [5:0]         vertex_index;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [31:0]        intensity;
        logic [31:0]        peak_so_far;
        logic               ended_in_sink;
        logic               last;
    } out_t;

    // One stored charge, as held by a ring cell.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] amt;
    } charge_t;

    // Status of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Trace sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_R2,
        ST_STEP,
        ST_SUB,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_CHK,
        ST_ROOT,
        ST_DIVM,
        ST_DIVUX,
        ST_MULX,
        ST_ACCX,
        ST_DIVUY,
        ST_MULY,
        ST_ACCY,
        ST_NEXT,
        ST_ALIGN,
        ST_LEN,
        ST_LSQX,
        ST_LSQY,
        ST_LSUM,
        ST_LROOT,
        ST_MOVX,
        ST_MDIVX,
        ST_MOVY,
        ST_MDIVY,
        ST_VERT,
        ST_SINK,
        ST_EMIT,
        ST_ADV,
        ST_FLUSH
    } state_t;

endpackage

@@ hdl/field_line_tracer.sv @@
// ============================================================================
// field_line_tracer: Euler tracer of one electric field line over a ring of
// stored point charges, emitting vertices of the traced line.
// ============================================================================
// A trace runs on the shared divider (one bit per cycle) and square root
// unit, and one word is worked on at a time. Each vertex waits in a pending
// register until the next vertex or the end of the line, then leaves through
// the output register.
// Reset clears the configuration to its defaults, the peak and all control;
// the charge cells are not cleared and must be loaded before use.
module field_line_tracer
    import fls_pkg::*;
#(
    parameter int MAX_CHARGES = MAX_CHARGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int KW    = $clog2(MAX_CHARGES + 1);
    localparam int ACC_W = 34 + $clog2(MAX_CHARGES + 1);
    localparam int FB    = FRAC_BITS;
    localparam logic signed [ACC_W-1:0] LIM_P = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] LIM_N = ACC_W'(-64'sh7FFF_FFFF);

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh8000_0000)
        begin
            r = -32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [4:0]  cnt_cfg_reg;
    logic [15:0] step_cfg_reg;
    logic [30:0] rad_cfg_reg;
    logic [7:0]  pcs_cfg_reg;
    logic [6:0]  seg_cfg_reg;

    logic        in_acc;
    logic        op_run_reg;
    logic        sink_reg;
    logic [KW-1:0] k_reg;
    logic        pend_valid_reg;
    out_t        pend_reg;
    logic        out_valid_reg;
    out_t        out_reg;
    out_t        out_next;
    out_t        vtx;
    logic [31:0] peak_reg;

    logic signed [31:0] px_reg, py_reg;
    logic [11:0]  line_id_reg;
    logic [KW-1:0] n_reg;
    logic [7:0]   pieces_reg;
    logic [13:0]  total_reg;
    logic [13:0]  piece_reg;
    logic [7:0]   pmod_reg;
    logic [5:0]   vidx_reg;
    logic [63:0]  r2_reg;
    logic [63:0]  d2_reg;
    logic [31:0]  ax_reg, ay_reg;
    logic         sgx_reg, sgy_reg;
    logic signed [15:0] amt_reg;
    logic [31:0]  d_reg;
    logic [31:0]  m_reg;
    logic [FB:0]  u_reg;
    logic signed [ACC_W-1:0] sx_reg, sy_reg;
    logic [30:0]  sxm_reg, sym_reg;
    logic         sxn_reg, syn_reg;
    logic [31:0]  len_reg;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p_reg;

    logic         div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [DIV_V-1:0] div_dvs;
    logic [DIV_W-1:0] div_q;
    unit_stat_t   div_stat;
    logic         sq_start;
    logic [SQ_W-1:0] sq_in;
    logic [SQ_W/2-1:0] sq_root;
    unit_stat_t   sq_stat;

    logic         ring_shift;
    charge_t      cell_q [MAX_CHARGES];
    logic [MAX_CHARGES-1:0] cell_load;
    charge_t      load_data;
    charge_t      head;

    logic         out_free;
    logic         out_load;
    logic         k_aligned;
    logic         sink_hit;
    logic         sink_emit;
    logic [31:0]  term;
    logic signed [ACC_W-1:0] term_s;
    logic signed [63:0] dxw, dyw;
    logic signed [31:0] dx, dy;
    logic [15:0]  amag;
    logic signed [63:0] mv;
    logic signed [63:0] mv_sum_x, mv_sum_y;
    logic [KW-1:0] n_init;
    logic [7:0]   pcs_init;
    logic [6:0]   seg_init;
    logic [14:0]  total_init;
    logic [7:0]   pmod_inc;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Charge ring: cell 0 is the head read by the sequencer.
    // ------------------------------------------------------------------
    assign load_data.x   = in_data.pos_x;
    assign load_data.y   = in_data.pos_y;
    assign load_data.amt = in_data.charge_amount;
    assign head          = cell_q[0];

    for (genvar i = 0; i < MAX_CHARGES; i++)
    begin : g_ring
        localparam int NB = (i + 1) % MAX_CHARGES;

        assign cell_load[i] = in_acc && (in_data.req_type == REQ_LOAD)
                              && (32'(in_data.charge_slot) == i);

        fls_cell u_cell (
            .clk       (clk),
            .load      (cell_load[i]),
            .load_data (load_data),
            .shift     (ring_shift),
            .neighbor  (cell_q[NB]),
            .q         (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Shared arithmetic units
    // ------------------------------------------------------------------
    fls_div #(.DW(DIV_W), .VW(DIV_V)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_stat)
    );

    fls_sqrt #(.IW(SQ_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .root     (sq_root),
        .stat     (sq_stat)
    );

    // Single registered multiplier.
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    assign dxw = 64'(px_reg) - 64'(head.x);
    assign dyw = 64'(py_reg) - 64'(head.y);
    assign dx  = sat_s32(dxw);
    assign dy  = sat_s32(dyw);
    assign amag = amt_reg[15] ? 16'(-17'(amt_reg)) : 16'(amt_reg);

    assign term   = mul_p_reg[FB+31:FB];
    assign term_s = $signed({{(ACC_W-32){1'b0}}, term});

    assign mv       = $signed({{(64-DIV_W){1'b0}}, div_q});
    assign mv_sum_x = 64'(px_reg) + (sxn_reg ? -mv : mv);
    assign mv_sum_y = 64'(py_reg) + (syn_reg ? -mv : mv);

    assign k_aligned = (k_reg == '0) || (k_reg == KW'(MAX_CHARGES));
    assign sink_hit  = amt_reg[15] && (d2_reg <= r2_reg);
    assign sink_emit = (piece_reg != '0) && (pmod_reg != 8'd1);
    assign pmod_inc  = (9'(pmod_reg) + 9'd1 == 9'(pieces_reg)) ? '0 : 8'(pmod_reg + 8'd1);

    // Trace setup values from the configuration.
    assign n_init   = (32'(cnt_cfg_reg) > MAX_CHARGES) ? KW'(MAX_CHARGES)
                                                       : KW'(cnt_cfg_reg);
    assign pcs_init = (pcs_cfg_reg == '0) ? 8'd1 : pcs_cfg_reg;
    assign seg_init = (seg_cfg_reg == '0) ? 7'd1
                    : ((32'(seg_cfg_reg) > MAX_VERTICES) ? 7'(MAX_VERTICES) : seg_cfg_reg);
    assign total_init = 15'(7'(seg_init - 7'd1) * pcs_init);

    // Vertex at the current point.
    always_comb
    begin
        vtx.out_line_id   = line_id_reg;
        vtx.vertex_index  = vidx_reg;
        vtx.vertex_x      = px_reg;
        vtx.vertex_y      = py_reg;
        vtx.intensity     = len_reg;
        vtx.peak_so_far   = peak_reg;
        vtx.ended_in_sink = 1'b0;
        vtx.last          = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.req_type == REQ_TRACE))
                begin
                    state_next = ST_R2;
                end
            end
            ST_R2:    state_next = ST_STEP;
            ST_STEP:  state_next = (n_reg == '0) ? ST_ALIGN : ST_SUB;
            ST_SUB:   state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_CHK;
            ST_CHK:
            begin
                if (sink_hit)
                begin
                    state_next = ST_ALIGN;
                end
                else if (d2_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:  state_next = sq_stat.done ? ST_DIVM : ST_ROOT;
            ST_DIVM:  state_next = div_stat.done ? ST_DIVUX : ST_DIVM;
            ST_DIVUX: state_next = div_stat.done ? ST_MULX : ST_DIVUX;
            ST_MULX:  state_next = ST_ACCX;
            ST_ACCX:  state_next = ST_DIVUY;
            ST_DIVUY: state_next = div_stat.done ? ST_MULY : ST_DIVUY;
            ST_MULY:  state_next = ST_ACCY;
            ST_ACCY:  state_next = ST_NEXT;
            ST_NEXT:  state_next = (KW'(k_reg + KW'(1)) == n_reg) ? ST_ALIGN : ST_SUB;
            ST_ALIGN:
            begin
                if (k_aligned)
                begin
                    state_next = sink_reg ? ST_SINK : ST_LEN;
                end
            end
            ST_LEN:   state_next = ST_LSQX;
            ST_LSQX:  state_next = ST_LSQY;
            ST_LSQY:  state_next = ST_LSUM;
            ST_LSUM:  state_next = ST_LROOT;
            ST_LROOT:
            begin
                if (sq_stat.done)
                begin
                    state_next = (sq_root != '0) ? ST_MOVX : ST_VERT;
                end
            end
            ST_MOVX:  state_next = ST_MDIVX;
            ST_MDIVX: state_next = div_stat.done ? ST_MOVY : ST_MDIVX;
            ST_MOVY:  state_next = ST_MDIVY;
            ST_MDIVY: state_next = div_stat.done ? ST_VERT : ST_MDIVY;
            ST_VERT:  state_next = (pmod_reg == '0) ? ST_EMIT : ST_ADV;
            ST_SINK:  state_next = sink_emit ? ST_EMIT : ST_FLUSH;
            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = sink_reg ? ST_FLUSH : ST_ADV;
                end
            end
            ST_ADV:   state_next = (piece_reg == total_reg) ? ST_FLUSH : ST_STEP;
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the units, the ring and the output register
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a      = 32'(rad_cfg_reg);
        mul_b      = 32'(rad_cfg_reg);
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = d_reg;
        sq_start   = 1'b0;
        sq_in      = d2_reg;
        ring_shift = 1'b0;
        out_load   = 1'b0;
        out_next   = pend_reg;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            ST_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_ROOT:
            begin
                sq_start = !op_run_reg;
            end
            ST_DIVM:
            begin
                div_start = !op_run_reg;
                div_dvd   = DIV_W'(amag) << (2 * FB - 8);
            end
            ST_DIVUX:
            begin
                div_start = !op_run_reg;
                div_dvd   = DIV_W'(ax_reg) << FB;
            end
            ST_DIVUY:
            begin
                div_start = !op_run_reg;
                div_dvd   = DIV_W'(ay_reg) << FB;
            end
            ST_MULX, ST_MULY:
            begin
                mul_a = 32'(u_reg);
                mul_b = m_reg;
            end
            ST_NEXT:
            begin
                ring_shift = 1'b1;
            end
            ST_ALIGN:
            begin
                ring_shift = !k_aligned;
            end
            ST_LSQX:
            begin
                mul_a = 32'(sxm_reg);
                mul_b = 32'(sxm_reg);
            end
            ST_LSQY:
            begin
                mul_a = 32'(sym_reg);
                mul_b = 32'(sym_reg);
            end
            ST_LROOT:
            begin
                sq_start = !op_run_reg;
            end
            ST_MOVX:
            begin
                mul_a = 32'(sxm_reg);
                mul_b = 32'(step_cfg_reg);
            end
            ST_MOVY:
            begin
                mul_a = 32'(sym_reg);
                mul_b = 32'(step_cfg_reg);
            end
            ST_MDIVX, ST_MDIVY:
            begin
                div_start = !op_run_reg;
                div_dvd   = mul_p_reg[DIV_W-1:0];
                div_dvs   = len_reg;
            end
            ST_EMIT:
            begin
                out_load = pend_valid_reg && out_free;
            end
            ST_FLUSH:
            begin
                out_load               = pend_valid_reg && out_free;
                out_next.last          = 1'b1;
                out_next.ended_in_sink = sink_reg;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_run_reg     <= 1'b0;
            sink_reg       <= 1'b0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            peak_reg       <= '0;
            cnt_cfg_reg    <= 5'd0;
            step_cfg_reg   <= 16'd655;
            rad_cfg_reg    <= 31'd65536;
            pcs_cfg_reg    <= 8'd4;
            seg_cfg_reg    <= 7'd32;
        end
        else
        begin
            state_reg <= state_next;

            // Unit launch tracking.
            if (div_start || sq_start)
            begin
                op_run_reg <= 1'b1;
            end
            else if (div_stat.done || sq_stat.done)
            begin
                op_run_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHARGE_COUNT: cnt_cfg_reg  <= cfg_data[4:0];
                    CFG_STEP_LENGTH:  step_cfg_reg <= cfg_data[15:0];
                    CFG_RADIUS:       rad_cfg_reg  <= cfg_data[30:0];
                    CFG_PIECES:       pcs_cfg_reg  <= cfg_data[7:0];
                    CFG_MAX_SEGMENTS: seg_cfg_reg  <= cfg_data[6:0];
                    default:          cnt_cfg_reg  <= cnt_cfg_reg;
                endcase
            end

            // Peak intensity.
            if (in_acc && (in_data.req_type == REQ_CLEAR))
            begin
                peak_reg <= '0;
            end
            else if ((state_reg == ST_LROOT) && sq_stat.done && (sq_root > peak_reg))
            begin
                peak_reg <= sq_root;
            end

            // Absorption flag.
            if (in_acc && (in_data.req_type == REQ_TRACE))
            begin
                sink_reg <= 1'b0;
            end
            else if ((state_reg == ST_CHK) && sink_hit)
            begin
                sink_reg <= 1'b1;
            end

            // Ring position.
            if (state_reg == ST_STEP)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_NEXT)
            begin
                k_reg <= KW'(k_reg + KW'(1));
            end
            else if (state_reg == ST_ALIGN)
            begin
                k_reg <= k_aligned ? '0 : KW'(k_reg + KW'(1));
            end

            // Pending vertex.
            if ((state_reg == ST_EMIT) && (!pend_valid_reg || out_free))
            begin
                pend_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_FLUSH) && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end

            // Output register.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    px_reg      <= in_data.pos_x;
                    py_reg      <= in_data.pos_y;
                    line_id_reg <= in_data.line_id;
                    n_reg       <= n_init;
                    pieces_reg  <= pcs_init;
                    total_reg   <= 14'(total_init);
                    piece_reg   <= '0;
                    pmod_reg    <= '0;
                    vidx_reg    <= '0;
                    len_reg     <= '0;
                end
            end
            ST_R2:
            begin
                r2_reg <= mul_p_reg;
            end
            ST_STEP:
            begin
                sx_reg <= '0;
                sy_reg <= '0;
            end
            ST_SUB:
            begin
                ax_reg  <= dx[31] ? 32'(-33'(dx)) : 32'(dx);
                ay_reg  <= dy[31] ? 32'(-33'(dy)) : 32'(dy);
                sgx_reg <= dx[31];
                sgy_reg <= dy[31];
                amt_reg <= head.amt;
            end
            ST_SQY, ST_LSQY:
            begin
                d2_reg <= mul_p_reg;
            end
            ST_SUM, ST_LSUM:
            begin
                d2_reg <= d2_reg + mul_p_reg;
            end
            ST_ROOT:
            begin
                if (sq_stat.done)
                begin
                    d_reg <= sq_root;
                end
            end
            ST_DIVM:
            begin
                if (div_stat.done)
                begin
                    m_reg <= (|div_q[DIV_W-1:32]) ? '1 : div_q[31:0];
                end
            end
            ST_DIVUX, ST_DIVUY:
            begin
                if (div_stat.done)
                begin
                    u_reg <= div_q[FB:0];
                end
            end
            ST_ACCX:
            begin
                sx_reg <= (sgx_reg ^ amt_reg[15]) ? sx_reg - term_s : sx_reg + term_s;
            end
            ST_ACCY:
            begin
                sy_reg <= (sgy_reg ^ amt_reg[15]) ? sy_reg - term_s : sy_reg + term_s;
            end
            ST_LEN:
            begin
                // Clamp the sums to the symmetric 32-bit range.
                sxn_reg <= sx_reg[ACC_W-1];
                syn_reg <= sy_reg[ACC_W-1];
                if (sx_reg > LIM_P || sx_reg < LIM_N)
                begin
                    sxm_reg <= '1;
                end
                else
                begin
                    sxm_reg <= sx_reg[ACC_W-1] ? 31'(-sx_reg) : 31'(sx_reg);
                end
                if (sy_reg > LIM_P || sy_reg < LIM_N)
                begin
                    sym_reg <= '1;
                end
                else
                begin
                    sym_reg <= sy_reg[ACC_W-1] ? 31'(-sy_reg) : 31'(sy_reg);
                end
            end
            ST_LROOT:
            begin
                if (sq_stat.done)
                begin
                    len_reg <= sq_root;
                end
            end
            ST_MDIVX:
            begin
                if (div_stat.done)
                begin
                    px_reg <= sat_s32(mv_sum_x);
                end
            end
            ST_MDIVY:
            begin
                if (div_stat.done)
                begin
                    py_reg <= sat_s32(mv_sum_y);
                end
            end
            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    pend_reg <= vtx;
                    vidx_reg <= 6'(vidx_reg + 6'd1);
                end
            end
            ST_ADV:
            begin
                piece_reg <= 14'(piece_reg + 14'd1);
                pmod_reg  <= pmod_inc;
            end
            default:
            begin
                r2_reg <= r2_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    // No vertex may be left behind when the sequencer returns to idle.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending vertex left at idle");

    // The charge ring is back at rest whenever the block is idle.
    a_idle_ring_rest: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> k_reg == '0)
        else $error("charge ring not at rest at idle");

    // Only a final vertex can report absorption.
    a_sink_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.ended_in_sink |-> out_reg.last)
        else $error("absorption flagged on a non-final vertex");

    // A word never overwrites one that is still held.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten");

    // The reported peak covers the reported intensity.
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.peak_so_far >= out_reg.intensity)
        else $error("peak below intensity");
`endif

endmodule

@@ hdl/fls_cell.sv @@
// ============================================================================
// fls_cell: one cell of the charge ring.
// Holds one charge; it takes a new charge from a load or from its neighbor
// when the ring rotates.
// ============================================================================
module fls_cell
    import fls_pkg::*;
(
    input  logic    clk,
    input  logic    load,
    input  charge_t load_data,
    input  logic    shift,
    input  charge_t neighbor,
    output charge_t q
);

    charge_t q_reg;

    // Load has priority; loads only happen while the ring is at rest.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= load_data;
        end
        else if (shift)
        begin
            q_reg <= neighbor;
        end
    end

    assign q = q_reg;

endmodule

@@ hdl/fls_div.sv @@
// ============================================================================
// fls_div: unsigned restoring divider.
// Produces one quotient bit per cycle; the quotient holds after done.
// ============================================================================
module fls_div
    import fls_pkg::*;
#(
    parameter int DW = DIV_W,
    parameter int VW = DIV_V
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output unit_stat_t    stat
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   rem_sh;
    logic          ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? VW'(rem_sh - {1'b0, dvs_reg}) : VW'(rem_sh);
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/fls_sqrt.sv @@
// ============================================================================
// fls_sqrt: unsigned floor square root.
// Consumes two radicand bits per cycle and yields one root bit per cycle.
// ============================================================================
module fls_sqrt
    import fls_pkg::*;
#(
    parameter int IW = SQ_W
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [IW-1:0]   radicand,
    output logic [IW/2-1:0] root,
    output unit_stat_t      stat
);

    localparam int OW = IW / 2;
    localparam int CW = $clog2(OW + 1);

    logic [IW-1:0]   val_reg;
    logic [OW+1:0]   rem_reg;
    logic [OW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [OW+3:0]   rem_sh;
    logic [OW+3:0]   trial;
    logic            ge;

    // Bring down two bits and compare against 4*root+1.
    assign rem_sh = {rem_reg, val_reg[IW-1:IW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[IW-3:0], 2'b00};
            rem_reg  <= ge ? (OW+2)'(rem_sh - trial) : (OW+2)'(rem_sh);
            root_reg <= {root_reg[OW-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ dv/field_line_tracer_tb.sv @@
// ----------------------------------------------------------------------------
// field_line_tracer_tb: self-checking bench of the field line tracer
// Loads charges, reprograms the count, step, radius, piece and segment
// registers, and traces lines under random idling on both word channels.
// Every accepted input word is run through a bit-exact predictor. Every
// output word is checked against the oldest predicted vertex.
// ----------------------------------------------------------------------------
module field_line_tracer_tb;
    import fls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A request code that the block ignores.
    localparam logic [1:0] REQ_NONE = 2'd3;
    // Cycles of one Euler step with every charge slot in use, with margin.
    localparam int SETTLE_CYCLES = 6000;
    localparam longint LIM_S32 = 64'sh7FFFFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Idle rates of the two sides, in percent.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;

    // Predictor state: charge cells, peak and register copies.
    longint          chg_x[16];
    longint          chg_y[16];
    longint          chg_amt[16];
    longint unsigned peak_field;
    logic [4:0]      reg_count;
    logic [15:0]     reg_step;
    logic [30:0]     reg_radius;
    logic [7:0]      reg_pieces;
    logic [6:0]      reg_segs;

    // Vertices predicted but not yet seen.
    out_t vertex_queue[$];

    field_line_tracer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("field_line_tracer_tb: errors");
        $finish;
    end

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat32(longint v);
        if (v > LIM_S32)
            return LIM_S32;
        if (v < -LIM_S32 - 1)
            return -LIM_S32 - 1;
        return v;
    endfunction

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint signed_as(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Traces one line and queues the vertices it emits.
    function automatic void predict_line(logic [11:0] id, longint px, longint py);
        longint unsigned n, pc, sg, total, piece, len, r2, k;
        longint unsigned ax, ay, d2, d, m, u;
        longint          sx, sy, dx, dy, a;
        bit              sink;
        out_t            line[$];
        out_t            v;
        n = (reg_count > 16) ? 16 : reg_count;
        pc = (reg_pieces != 0) ? reg_pieces : 1;
        sg = (reg_segs != 0) ? reg_segs : 1;
        if (sg > MAX_VERTICES)
            sg = MAX_VERTICES;
        total = (sg - 1) * pc;
        r2 = longint'(reg_radius) * longint'(reg_radius);
        len = 0;
        sink = 1'b0;
        for (piece = 0; piece <= total && !sink; piece++)
        begin
            sx = 0;
            sy = 0;
            for (k = 0; k < n; k++)
            begin
                dx = sat32(px - chg_x[k]);
                dy = sat32(py - chg_y[k]);
                a = chg_amt[k];
                ax = mag64(dx);
                ay = mag64(dy);
                d2 = ax * ax + ay * ay;
                if (a < 0 && d2 <= r2)
                begin
                    sink = 1'b1;
                    break;
                end
                if (d2 == 0)
                    continue;
                d = isqrt64(d2);
                m = (mag64(a) << (2 * FRAC_BITS - 8)) / d;
                if (m > 64'hFFFFFFFF)
                    m = 64'hFFFFFFFF;
                u = (ax << FRAC_BITS) / d;
                sx += signed_as((u * m) >> FRAC_BITS, (dx < 0) != (a < 0));
                u = (ay << FRAC_BITS) / d;
                sy += signed_as((u * m) >> FRAC_BITS, (dy < 0) != (a < 0));
            end
            v = '0;
            v.out_line_id = id;
            v.vertex_index = 6'(line.size());
            if (sink)
            begin
                // Absorbed: a closing vertex at the current point, except on the
                // very first step or, with more than one piece, right after a vertex.
                if (piece != 0 && piece % pc != 1)
                begin
                    v.vertex_x = px[31:0];
                    v.vertex_y = py[31:0];
                    v.intensity = len[31:0];
                    v.peak_so_far = peak_field[31:0];
                    line.push_back(v);
                end
                break;
            end
            if (sx > LIM_S32) sx = LIM_S32;
            if (sx < -LIM_S32) sx = -LIM_S32;
            if (sy > LIM_S32) sy = LIM_S32;
            if (sy < -LIM_S32) sy = -LIM_S32;
            len = isqrt64(mag64(sx) * mag64(sx) + mag64(sy) * mag64(sy));
            if (len > peak_field)
                peak_field = len;
            // A zero field leaves the point where it is.
            if (len != 0)
            begin
                px = sat32(px + signed_as(mag64(sx) * reg_step / len, sx < 0));
                py = sat32(py + signed_as(mag64(sy) * reg_step / len, sy < 0));
            end
            if (piece % pc == 0 && line.size() < MAX_VERTICES)
            begin
                v.vertex_x = px[31:0];
                v.vertex_y = py[31:0];
                v.intensity = len[31:0];
                v.peak_so_far = peak_field[31:0];
                line.push_back(v);
            end
        end
        if (line.size() > 0)
        begin
            line[line.size() - 1].ended_in_sink = sink;
            line[line.size() - 1].last = 1'b1;
        end
        foreach (line[i])
            vertex_queue.push_back(line[i]);
    endfunction

    function automatic void predict_word(in_t w);
        case (w.req_type)
            REQ_LOAD:
            begin
                chg_x[w.charge_slot] = longint'(w.pos_x);
                chg_y[w.charge_slot] = longint'(w.pos_y);
                chg_amt[w.charge_slot] = longint'(w.charge_amount);
            end
            REQ_TRACE: predict_line(w.line_id, longint'(w.pos_x), longint'(w.pos_y));
            REQ_CLEAR: peak_field = 0;
            default: ;
        endcase
    endfunction

    // Sends one word; valid stays high into the next word unless a gap is taken.
    task automatic send_word(in_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(w);
    endtask

    // Drops valid, waits for every vertex, then lets the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (vertex_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register; valid stays high for the next write of a burst.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CHARGE_COUNT: reg_count = val[4:0];
            CFG_STEP_LENGTH:  reg_step = val[15:0];
            CFG_RADIUS:       reg_radius = val[30:0];
            CFG_PIECES:       reg_pieces = val[7:0];
            CFG_MAX_SEGMENTS: reg_segs = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int cnt, int stp, int rad, int pcs, int sgs);
        write_reg(CFG_CHARGE_COUNT, cnt);
        write_reg(CFG_STEP_LENGTH, stp);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_PIECES, pcs);
        write_reg(CFG_MAX_SEGMENTS, sgs);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_t make_word(logic [1:0] req, logic [3:0] slot, int x, int y,
                                      int amt, logic [11:0] id);
        in_t w;
        w.req_type = req;
        w.charge_slot = slot;
        w.pos_x = x;
        w.pos_y = y;
        w.charge_amount = 16'(amt);
        w.line_id = id;
        return w;
    endfunction

    function automatic int near_coord();
        return $signed($urandom_range(1310720)) - 655360;
    endfunction

    // Receiver: stall at random, check every word taken.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (vertex_queue.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected vertex: %p", out_data);
            end
            else
            begin
                if (out_data !== vertex_queue[0])
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("vertex mismatch: expected %p, got %p",
                                 vertex_queue[0], out_data);
                end
                void'(vertex_queue.pop_front());
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Fill every cell, with the extremes of the fields among them.
    task automatic test_load_cells();
        send_word(make_word(REQ_LOAD, 4'd0, 0, 0, 32767, 12'hFFF));
        send_word(make_word(REQ_LOAD, 4'd1, 131072, 65536, -32768, 12'h000));
        send_word(make_word(REQ_LOAD, 4'd2, 32'h7FFFFFFF, 32'h80000000, 256, 12'h555));
        send_word(make_word(REQ_LOAD, 4'd3, 32'h80000000, 32'h7FFFFFFF, -1, 12'hAAA));
        for (int s = 4; s < 16; s++)
            send_word(make_word(REQ_LOAD, 4'(s), near_coord(), near_coord(),
                                $signed($urandom_range(65535)) - 32768, 12'($urandom)));
    endtask

    // Register extremes, zero field, first-step absorption, clear and ignore.
    task automatic test_register_extremes();
        settle();
        set_regs(0, 655, 65536, 4, 4);
        send_word(make_word(REQ_TRACE, 4'hF, 100, -100, 0, 12'h001));
        settle();
        set_regs(31, 65535, 0, 1, 1);
        send_word(make_word(REQ_TRACE, 4'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 12'hFFF));
        settle();
        set_regs(1, 1, 1000, 0, 127);
        send_word(make_word(REQ_TRACE, 4'h0, 65536, 0, 0, 12'h123));
        settle();
        set_regs(2, 65535, 32'h7FFFFFFF, 255, 2);
        send_word(make_word(REQ_TRACE, 4'h0, 65536, 65536, 0, 12'h234));
        settle();
        set_regs(1, 40000, 65536, 255, 2);
        send_word(make_word(REQ_TRACE, 4'h0, 32'h80000000, 32'h80000000, 0, 12'h345));
        send_word(make_word(REQ_CLEAR, 4'h0, 0, 0, 0, 12'h0));
        send_word(make_word(REQ_NONE, 4'h5, 1, 1, 1, 12'h6));
        settle();
        set_regs(2, 16384, 65536, 1, 64);
        send_word(make_word(REQ_TRACE, 4'h0, 200000, 0, 0, 12'h456));
    endtask

    // Random configurations and words; each phase switches the idling.
    task automatic test_random_words();
        int   mode;
        in_t  w;
        logic [1:0] req;
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            mode = phase % 4;
            send_idle_pct = (mode == 1) ? 46 : (mode == 3) ? 14 : 0;
            recv_stall_pct = (mode == 2) ? 46 : (mode == 3) ? 14 : 0;
            set_regs($urandom_range(1, 3), $urandom_range(1, 65535),
                     $urandom_range(131072), $urandom_range(1, 3), $urandom_range(1, 6));
            for (int i = 0; i < 12; i++)
            begin
                case ($urandom_range(99)) inside
                    [0:39]:  req = REQ_LOAD;
                    [40:86]: req = REQ_TRACE;
                    [87:94]: req = REQ_CLEAR;
                    default: req = REQ_NONE;
                endcase
                w = '0;
                w.req_type = req;
                if ($urandom_range(9) != 0)
                begin
                    w.pos_x = near_coord();
                    w.pos_y = near_coord();
                end
                else
                begin
                    w.pos_x = $urandom;
                    w.pos_y = $urandom;
                end
                w.charge_amount = 16'($urandom);
                w.line_id = 12'($urandom);
                // Keep most loads on cells 0 to 2, the most that a phase puts in use.
                if (req == REQ_LOAD && $urandom_range(3) != 0)
                    w.charge_slot = 4'($urandom_range(2));
                else
                    w.charge_slot = 4'($urandom);
                send_word(w);
            end
        end
    endtask

    initial
    begin
        peak_field = 0;
        reg_count = 5'd0;
        reg_step = 16'd655;
        reg_radius = 31'd65536;
        reg_pieces = 8'd4;
        reg_segs = 7'd32;
        foreach (chg_x[i])
        begin
            chg_x[i] = 0;
            chg_y[i] = 0;
            chg_amt[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_cells();
        test_register_extremes();
        test_random_words();
        settle();
        if (err_count == 0)
            $display("field_line_tracer_tb: clean");
        else
            $display("field_line_tracer_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/fls_pkg.sv
hdl/fls_cell.sv
hdl/fls_div.sv
hdl/fls_sqrt.sv
hdl/field_line_tracer.sv
dv/field_line_tracer_tb.sv
